[src/sec_pkg.sv]
// Shared types and constants for the sound event coalescing queue.
// Used by every module of the block; no dependencies.
package sec_pkg;

  // Block sizing
  localparam int SLOTS        = 12;
  localparam int MAX_PER_SLOT = 128;
  localparam int NUM_SOUNDS   = 46;

  // Field widths
  localparam int SOUND_W = 6;
  localparam int PAN_W   = 15;
  localparam int CNT_W   = $clog2(MAX_PER_SLOT + 1);
  localparam int SUM_W   = PAN_W + $clog2(MAX_PER_SLOT);
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W  = $clog2(SLOTS + 1);
  localparam int DIV_CW  = $clog2(SUM_W + 1);

  // Stream payload: sound in the low bits, pan above, padded to bytes
  localparam int DATA_W = ((SOUND_W + PAN_W + 7) / 8) * 8;

  // Register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  // Register select (paddr[3])
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LOADED = 1'b1;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_FLUSH   = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ_RD,
    ST_ENQ_CHK,
    ST_ENQ_NEW,
    ST_FL_RD,
    ST_FL_CHK,
    ST_FL_DIV,
    ST_FL_PUSH,
    ST_FL_NEXT,
    ST_FL_END
  } state_e;

  // One slot entry as held in the slot memory
  typedef struct packed {
    logic [SOUND_W-1:0]      sound;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } slot_t;

  // Divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[src/sec_slot_ram.sv]
// Slot memory: one write port, one read port, registered read data.
// Depends on sec_pkg for the slot entry type.
module sec_slot_ram
  import sec_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [SLOT_AW-1:0] waddr_i,
  input  slot_t              wdata_i,
  input  logic [SLOT_AW-1:0] raddr_i,
  output slot_t              rdata_o
);

  slot_t mem [SLOTS];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, read data registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/sec_div.sv]
// Serial signed divider: pan sum by request count, one quotient bit a cycle.
// Quotient is truncated toward zero. Depends on sec_pkg.
module sec_div
  import sec_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic [PAN_W-1:0]        quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [SUM_W-1:0]  signed_quo;

  // Restoring step on magnitudes
  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(SUM_W);
      rem_d  = '0;
      quo_d  = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
    end else if (busy_q) begin
      rem_d = ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign signed_quo = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign quotient_o = signed_quo[PAN_W-1:0];
  assign done_o     = done_q;

endmodule

[src/sound_event_coalescing_queue.sv]
// Top level of the sound event coalescing queue: control sequencer, registers
// and output stage. Depends on sec_pkg, sec_slot_ram and sec_div.
//
// Requests are taken one at a time. An enqueue walks the occupied slots in
// the slot memory, reading each slot and then comparing it and writing it
// back; an enqueue for an unknown sound number finishes in its accept cycle.
// A flush that finds the block enabled reads and checks each occupied slot.
// An unloaded sound then moves on. A loaded sound runs the serial divider to
// form the average pan, then hands the result on and moves on. A flush also
// waits while the output side stalls. The slot memory's single read port and
// the bit-serial divider set the pace of enqueues and flushes.
// Results of a flush are handed out through an output register with one
// result held back so the final one can carry tlast. The slot memory needs
// no clearing after reset: a fill count marks which slots are occupied.
module sound_event_coalescing_queue
  import sec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // [5:0] sound_number, [20:6] pan
  input  logic               s_axis_tuser,   // [0] opcode
  // Result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,   // [5:0] play_sound, [20:6] play_pan
  output logic               m_axis_tlast,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_e state_q, state_d;

  logic [SLOT_AW-1:0]     idx_q, idx_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic                   enable_q;
  logic [NUM_SOUNDS-1:0]  loaded_q;
  logic [SOUND_W-1:0]     req_sound_q, req_sound_d;
  logic [PAN_W-1:0]       req_pan_q, req_pan_d;
  logic [SOUND_W-1:0]     cur_sound_q, cur_sound_d;
  logic                   held_v_q, held_v_d;
  logic [SOUND_W-1:0]     held_sound_q, held_sound_d;
  logic [PAN_W-1:0]       held_pan_q, held_pan_d;
  logic                   m_valid_q, m_valid_d;
  logic [SOUND_W-1:0]     m_sound_q, m_sound_d;
  logic [PAN_W-1:0]       m_pan_q, m_pan_d;
  logic                   m_last_q, m_last_d;

  logic                   in_req;
  logic                   in_known;
  op_e                    in_op;
  logic [SOUND_W-1:0]     in_sound;
  logic                   out_free;
  logic                   last_slot;
  logic                   slots_full;
  logic                   cfg_wr;

  logic                   ram_we;
  logic [SLOT_AW-1:0]     ram_waddr;
  slot_t                  ram_wdata;
  slot_t                  ram_rdata;
  div_ctl_t               div_ctl;
  logic                   div_done;
  logic [PAN_W-1:0]       div_quo;

  // Decode of the incoming request
  assign in_req    = s_axis_tvalid && s_axis_tready;
  assign in_op     = op_e'(s_axis_tuser);
  assign in_sound  = s_axis_tdata[SOUND_W-1:0];
  assign in_known  = {1'b0, in_sound} < (SOUND_W + 1)'(NUM_SOUNDS);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign last_slot = (FILL_W'(idx_q) + FILL_W'(1)) == fill_q;
  assign slots_full = fill_q == FILL_W'(SLOTS);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          if (in_op == OP_ENQUEUE) begin
            if (in_known) begin
              state_d = (fill_q == '0) ? ST_ENQ_NEW : ST_ENQ_RD;
            end
          end else if (enable_q && fill_q != '0) begin
            state_d = ST_FL_RD;
          end
        end
      end
      ST_ENQ_RD:  state_d = ST_ENQ_CHK;
      ST_ENQ_CHK: begin
        if (ram_rdata.sound == req_sound_q) begin
          state_d = ST_IDLE;
        end else if (last_slot) begin
          state_d = slots_full ? ST_IDLE : ST_ENQ_NEW;
        end else begin
          state_d = ST_ENQ_RD;
        end
      end
      ST_ENQ_NEW: state_d = ST_IDLE;
      ST_FL_RD:   state_d = ST_FL_CHK;
      ST_FL_CHK:  state_d = loaded_q[ram_rdata.sound] ? ST_FL_DIV : ST_FL_NEXT;
      ST_FL_DIV:  state_d = div_ctl.done ? ST_FL_PUSH : ST_FL_DIV;
      ST_FL_PUSH: begin
        if (!held_v_q || out_free) begin
          state_d = ST_FL_NEXT;
        end
      end
      ST_FL_NEXT: state_d = last_slot ? ST_FL_END : ST_FL_RD;
      ST_FL_END: begin
        if (!held_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_d        = idx_q;
    fill_d       = fill_q;
    req_sound_d  = req_sound_q;
    req_pan_d    = req_pan_q;
    cur_sound_d  = cur_sound_q;
    held_v_d     = held_v_q;
    held_sound_d = held_sound_q;
    held_pan_d   = held_pan_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_sound_d    = m_sound_q;
    m_pan_d      = m_pan_q;
    m_last_d     = m_last_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '{sound: req_sound_q,
                     sum:   SUM_W'($signed(req_pan_q)),
                     count: CNT_W'(1)};
    div_ctl.start = 1'b0;
    div_ctl.done  = div_done;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        idx_d         = '0;
        held_v_d      = 1'b0;
        if (in_req) begin
          req_sound_d = in_sound;
          req_pan_d   = s_axis_tdata[SOUND_W +: PAN_W];
        end
      end
      ST_ENQ_CHK: begin
        if (ram_rdata.sound == req_sound_q) begin
          // Join the slot unless it already holds the maximum
          if (ram_rdata.count < CNT_W'(MAX_PER_SLOT)) begin
            ram_we          = 1'b1;
            ram_wdata.sum   = ram_rdata.sum + SUM_W'($signed(req_pan_q));
            ram_wdata.count = ram_rdata.count + CNT_W'(1);
          end
        end else if (!last_slot) begin
          idx_d = idx_q + SLOT_AW'(1);
        end
      end
      ST_ENQ_NEW: begin
        // Claim the first empty slot
        ram_we    = 1'b1;
        ram_waddr = fill_q[SLOT_AW-1:0];
        fill_d    = fill_q + FILL_W'(1);
      end
      ST_FL_CHK: begin
        cur_sound_d   = ram_rdata.sound;
        div_ctl.start = loaded_q[ram_rdata.sound];
      end
      ST_FL_PUSH: begin
        // Keep one result back; the held one goes out when another arrives
        if (!held_v_q) begin
          held_v_d     = 1'b1;
          held_sound_d = cur_sound_q;
          held_pan_d   = div_quo;
        end else if (out_free) begin
          m_valid_d    = 1'b1;
          m_sound_d    = held_sound_q;
          m_pan_d      = held_pan_q;
          m_last_d     = 1'b0;
          held_sound_d = cur_sound_q;
          held_pan_d   = div_quo;
        end
      end
      ST_FL_NEXT: begin
        if (!last_slot) begin
          idx_d = idx_q + SLOT_AW'(1);
        end
      end
      ST_FL_END: begin
        if (!held_v_q) begin
          fill_d = '0;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_sound_d = held_sound_q;
          m_pan_d   = held_pan_q;
          m_last_d  = 1'b1;
          held_v_d  = 1'b0;
          fill_d    = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      fill_q    <= '0;
      held_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      fill_q    <= fill_d;
      held_v_q  <= held_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_sound_q  <= req_sound_d;
    req_pan_q    <= req_pan_d;
    cur_sound_q  <= cur_sound_d;
    held_sound_q <= held_sound_d;
    held_pan_q   <= held_pan_d;
    m_sound_q    <= m_sound_d;
    m_pan_q      <= m_pan_d;
    m_last_q     <= m_last_d;
  end

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      loaded_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_ENABLE) begin
        enable_q <= pwdata[0];
      end else begin
        loaded_q <= pwdata[NUM_SOUNDS-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_LOADED) ? PDATA_W'(loaded_q) : PDATA_W'(enable_q);

  // Slot memory
  sec_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Average pan divider
  sec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (ram_rdata.sum),
    .divisor_i  (ram_rdata.count),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Result stream
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DATA_W'({m_pan_q, m_sound_q});
  assign m_axis_tlast  = m_last_q;

endmodule

[src/sec_checker.sv]
// Port-level checks for the sound event coalescing queue, bound to the top.
// Depends on sec_pkg.
module sec_checker
  import sec_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Results only come out of a flush in progress, when requests are held off
  a_out_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared outside a flush");

  // Only known sound numbers are played
  a_sound_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[SOUND_W-1:0]} < (SOUND_W + 1)'(NUM_SOUNDS)))
    else $error("unknown sound number played");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DATA_W-1:SOUND_W+PAN_W] == '0))
    else $error("padding bits set in result");

endmodule

bind sound_event_coalescing_queue sec_checker u_sec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
